// File: rtl/core/sdds_pkg.sv
package sdds_pkg;

    localparam int unsigned SEQ_DEPTH = 5;
    localparam int unsigned CNT_W     = 3;

    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    localparam logic [1:0] POS_START    = 2'd0;
    localparam logic [1:0] POS_INSIDE   = 2'd1;
    localparam logic [1:0] POS_AFTER_CR = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       message_done;
    } t_out;

endpackage

// File: rtl/core/smtp_data_dot_stuffer.sv
// a request's first byte is registered in the run buffer, then in the output register
// output: one byte per cycle while i_out_stall is low; a request producing n bytes (1 to 5)
// holds the input while more than its last byte remains in the run buffer
// the run buffer accepts the next request on the cycle its last byte moves out
// reset (i_rst_n low, synchronous) returns to line start with both stages empty
module smtp_data_dot_stuffer import sdds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    logic res_valid;
    t_out res_data;
    logic res_take;

    sdds_expand u_expand (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res_data  (res_data),
        .i_res_take  (res_take)
    );

    sdds_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_data  (res_data),
        .o_res_take  (res_take),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: rtl/core/sdds_expand.sv
module sdds_expand import sdds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_res_valid,
    output t_out o_res_data,
    input  logic i_res_take
);

    logic [1:0]       r_pos, n_pos;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_eom, n_eom;
    logic [7:0]       r_seq [SEQ_DEPTH];
    logic [7:0]       n_seq [SEQ_DEPTH];

    logic [7:0]       g_seq [SEQ_DEPTH];
    logic [CNT_W-1:0] g_cnt;
    logic [1:0]       g_pos;
    logic             accept;
    logic [7:0]       c;

    assign c = i_in_data.data_byte;

    // expansion of one request into its byte run
    always_comb begin
        for (int k = 0; k < SEQ_DEPTH; k++) begin
            g_seq[k] = CH_LF;
        end
        g_cnt = CNT_W'(1);
        g_pos = r_pos;
        if (i_in_data.end_of_message) begin
            g_pos = POS_START;
            if (r_pos == POS_INSIDE) begin
                g_seq[0] = CH_CR;
                g_seq[1] = CH_LF;
                g_seq[2] = CH_DOT;
                g_seq[3] = CH_CR;
                g_seq[4] = CH_LF;
                g_cnt    = CNT_W'(5);
            end else if (r_pos == POS_AFTER_CR) begin
                g_seq[0] = CH_LF;
                g_seq[1] = CH_DOT;
                g_seq[2] = CH_CR;
                g_seq[3] = CH_LF;
                g_cnt    = CNT_W'(4);
            end else begin
                g_seq[0] = CH_DOT;
                g_seq[1] = CH_CR;
                g_seq[2] = CH_LF;
                g_cnt    = CNT_W'(3);
            end
        end else if (r_pos == POS_AFTER_CR) begin
            g_seq[0] = c;
            if (c == CH_LF) begin
                g_pos = POS_START;
            end else if (c != CH_CR) begin
                g_pos = POS_INSIDE;
            end
        end else if (c == CH_LF) begin
            g_seq[0] = CH_CR;
            g_seq[1] = CH_LF;
            g_cnt    = CNT_W'(2);
            g_pos    = POS_START;
        end else if (c == CH_CR) begin
            g_seq[0] = CH_CR;
            g_pos    = POS_AFTER_CR;
        end else begin
            g_pos = POS_INSIDE;
            if (r_pos != POS_INSIDE && c == CH_DOT) begin
                g_seq[0] = CH_DOT;
                g_seq[1] = CH_DOT;
                g_cnt    = CNT_W'(2);
            end else begin
                g_seq[0] = c;
            end
        end
    end

    assign o_in_stall = (r_left > CNT_W'(1)) || ((r_left == CNT_W'(1)) && !i_res_take);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_pos  = r_pos;
        n_left = r_left;
        n_eom  = r_eom;
        for (int k = 0; k < SEQ_DEPTH; k++) begin
            n_seq[k] = r_seq[k];
        end
        if (accept) begin
            n_pos  = g_pos;
            n_left = g_cnt;
            n_eom  = i_in_data.end_of_message;
            for (int k = 0; k < SEQ_DEPTH; k++) begin
                n_seq[k] = g_seq[k];
            end
        end else if (i_res_take) begin
            n_left = r_left - CNT_W'(1);
            for (int k = 0; k < SEQ_DEPTH - 1; k++) begin
                n_seq[k] = r_seq[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_START;
            r_left <= '0;
            r_eom  <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_left <= n_left;
            r_eom  <= n_eom;
        end
        for (int k = 0; k < SEQ_DEPTH; k++) begin
            r_seq[k] <= n_seq[k];
        end
    end

    assign o_res_valid             = (r_left != '0);
    assign o_res_data.out_byte     = r_seq[0];
    assign o_res_data.last_of_run  = (r_left == CNT_W'(1));
    assign o_res_data.message_done = r_eom && (r_left == CNT_W'(1));

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CNT_W'(SEQ_DEPTH))
        else $error("run length out of range");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_left != '0))
        else $error("accepted request produced no bytes");

    a_pos_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3)
        else $error("illegal line position");

    a_eom_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.end_of_message) |=> (r_pos == POS_START))
        else $error("line position not at start after message end");

endmodule

// File: rtl/core/sdds_outreg.sv
module sdds_outreg import sdds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_res_valid,
    input  t_out i_res_data,
    output logic o_res_take,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    logic r_valid, n_valid;
    t_out r_data, n_data;

    assign o_res_take = i_res_valid && (!r_valid || !i_out_stall);

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (o_res_take) begin
            n_valid = 1'b1;
            n_data  = i_res_data;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_take |=> r_valid)
        else $error("taken result not registered");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.message_done) |-> r_data.last_of_run)
        else $error("message done without end of run");

    a_done_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.message_done) |-> (r_data.out_byte == CH_LF))
        else $error("message done on a byte other than LF");

endmodule
